// ----- design/hbwd_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the heartbeat tracker.
package hbwd_pkg;

    localparam int WINDOW_DEF     = 16;
    localparam int NODES_DEF      = 64;
    localparam int ROUND_BITS_DEF = 32;

    localparam int OWN_W      = 6;
    localparam int FAULTY_W   = 5;
    localparam int SPAN_W     = 4;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_ADDR_W = 2;
    localparam int ACTION_W   = 2;
    localparam int CNT_W      = 7;
    localparam int GRP_CNT_W  = 4;

    localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd4;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RECV  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_OWN_ID       = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAULTY_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT_SPAN = 2'd2;

    typedef struct packed {
        logic latch;
        logic tick;
        logic claim_wr;
        logic scan_rd;
        logic scan_chk;
        logic fin;
        logic to_cnt;
        logic to_done;
    } t_cmd;

    typedef struct packed {
        logic faulty;
        logic rx_ok;
        logic scan_end;
    } t_sts;

endpackage

// ----- design/hbwd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hbwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/hbwd_ctrl.sv -----
// Controller state machine: sequences claim, scan and timeout work on the datapath.
module hbwd_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [hbwd_pkg::ACTION_W-1:0]  i_action,
    input  hbwd_pkg::t_sts                 i_sts,
    output hbwd_pkg::t_cmd                 o_cmd,
    output logic                           o_busy
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_CLAIM_RD = 9'b000000010,
        S_CLAIM_WR = 9'b000000100,
        S_SCAN     = 9'b000001000,
        S_DRAIN    = 9'b000010000,
        S_FIN      = 9'b000100000,
        S_TO_RD    = 9'b001000000,
        S_TO_CNT   = 9'b010000000,
        S_TO_SUM   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_send, n_is_send;

    always_comb begin
        n_state   = r_state;
        n_is_send = r_is_send;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    case (i_action)
                        hbwd_pkg::ACT_TICK: begin
                            o_cmd.tick = 1'b1;
                        end
                        hbwd_pkg::ACT_SEND: begin
                            if (!i_sts.faulty) begin
                                n_state   = S_CLAIM_RD;
                                n_is_send = 1'b1;
                            end
                        end
                        hbwd_pkg::ACT_RECV: begin
                            if (!i_sts.faulty && i_sts.rx_ok) begin
                                n_state   = S_CLAIM_RD;
                                n_is_send = 1'b0;
                            end
                        end
                        default: begin
                            n_state = S_TO_RD;
                        end
                    endcase
                end
            end
            S_CLAIM_RD: begin
                n_state = S_CLAIM_WR;
            end
            S_CLAIM_WR: begin
                o_cmd.claim_wr = 1'b1;
                n_state        = r_is_send ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                o_cmd.scan_rd  = 1'b1;
                o_cmd.scan_chk = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                o_cmd.scan_chk = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            S_TO_RD: begin
                n_state = S_TO_CNT;
            end
            S_TO_CNT: begin
                o_cmd.to_cnt = 1'b1;
                n_state      = S_TO_SUM;
            end
            S_TO_SUM: begin
                o_cmd.to_done = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_send <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_send <= n_is_send;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- design/hbwd_dpath.sv -----
// Datapath: config, round counter, slot RAM with valid bits, scan pipeline, popcount, outputs.
module hbwd_dpath #(
    parameter int WINDOW     = hbwd_pkg::WINDOW_DEF,
    parameter int NODES      = hbwd_pkg::NODES_DEF,
    parameter int ROUND_BITS = hbwd_pkg::ROUND_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbwd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [hbwd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [hbwd_pkg::ACTION_W-1:0]    i_action,
    input  logic [ROUND_BITS-1:0]            i_entry_round,
    input  logic [NODES-1:0]                 i_entry_mask,
    input  hbwd_pkg::t_cmd                   i_cmd,
    output hbwd_pkg::t_sts                   o_sts,
    output logic                             o_valid,
    output logic                             o_is_entry,
    output logic [ROUND_BITS-1:0]            o_out_round,
    output logic [NODES-1:0]                 o_out_mask,
    output logic                             o_last,
    output logic                             o_expired
);

    localparam int LW     = $clog2(WINDOW);
    localparam int DW     = ROUND_BITS + NODES;
    localparam int GROUPS = (NODES + 7) / 8;
    localparam int PADW   = GROUPS * 8;

    logic [hbwd_pkg::OWN_W-1:0]    r_own_id;
    logic [hbwd_pkg::FAULTY_W-1:0] r_faulty;
    logic [hbwd_pkg::SPAN_W-1:0]   r_span;

    logic [ROUND_BITS-1:0] r_cur;
    logic [WINDOW-1:0]     r_valid;

    logic [ROUND_BITS-1:0] r_round, n_round;
    logic [NODES-1:0]      r_mask, n_mask;
    logic                  r_skip;

    logic [LW-1:0] r_scan;
    logic [LW-1:0] r_dk;
    logic          r_dv;

    logic                  r_pend_v, n_pend_v;
    logic [ROUND_BITS-1:0] r_pend_round;
    logic [NODES-1:0]      r_pend_mask;

    logic [hbwd_pkg::GRP_CNT_W-1:0] r_grp [GROUPS];
    logic [hbwd_pkg::GRP_CNT_W-1:0] grp_cnt [GROUPS];
    logic                           r_hit;

    logic                  r_o_valid, n_o_valid;
    logic                  r_o_is_entry, n_o_is_entry;
    logic [ROUND_BITS-1:0] r_o_round, n_o_round;
    logic [NODES-1:0]      r_o_mask, n_o_mask;
    logic                  r_o_last, n_o_last;
    logic                  r_o_timed, n_o_timed;

    logic                  faulty;
    logic [NODES-1:0]      own_bit;
    logic [ROUND_BITS+1:0] up_lim;
    logic [ROUND_BITS:0]   low_sum;
    logic                  rx_ok;
    logic [ROUND_BITS-1:0] check_round;
    logic                  before_span;

    logic [LW-1:0]         slot;
    logic [LW-1:0]         rd_addr;
    logic [DW-1:0]         rd_data;
    logic [ROUND_BITS-1:0] rd_stamp;
    logic [NODES-1:0]      rd_seen;
    logic                  claim_hit;
    logic [NODES-1:0]      wr_seen;
    logic                  live;
    logic [PADW-1:0]       seen_pad;
    logic [hbwd_pkg::CNT_W-1:0] total;
    logic [hbwd_pkg::CNT_W-1:0] quorum;
    logic                  quorum_ok;

    // config and status
    assign faulty = {1'b0, r_faulty} > r_own_id;

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            own_bit[i] = (r_own_id == hbwd_pkg::OWN_W'(i));
        end
    end

    assign up_lim  = {2'b00, r_cur} + (ROUND_BITS + 2)'(2);
    assign low_sum = {1'b0, i_entry_round} + (ROUND_BITS + 1)'(r_span);
    assign rx_ok   = (i_entry_round != '1) && ({2'b00, i_entry_round} <= up_lim)
                     && (low_sum >= {1'b0, r_cur});

    assign check_round = r_cur - ROUND_BITS'(r_span) + ROUND_BITS'(1);
    assign before_span = r_cur < ROUND_BITS'(r_span);

    assign o_sts.faulty   = faulty;
    assign o_sts.rx_ok    = rx_ok;
    assign o_sts.scan_end = &r_scan;

    // slot RAM
    assign slot    = r_round[LW-1:0];
    assign rd_addr = i_cmd.scan_rd ? r_scan : slot;

    assign rd_stamp  = rd_data[DW-1:NODES];
    assign rd_seen   = rd_data[NODES-1:0];
    assign claim_hit = r_valid[slot] && (rd_stamp == r_round);
    assign wr_seen   = (claim_hit ? rd_seen : '0) | r_mask;

    hbwd_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (i_cmd.claim_wr),
        .i_waddr (slot),
        .i_wdata ({r_round, wr_seen}),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // popcount: byte counts, then a sum
    assign seen_pad = PADW'(rd_seen);

    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            grp_cnt[g] = '0;
            for (int b = 0; b < 8; b++) begin
                grp_cnt[g] = grp_cnt[g] + hbwd_pkg::GRP_CNT_W'(seen_pad[g*8+b]);
            end
        end
    end

    always_comb begin
        total = '0;
        for (int g = 0; g < GROUPS; g++) begin
            total = total + hbwd_pkg::CNT_W'(r_grp[g]);
        end
    end

    assign quorum    = {1'b0, r_faulty, 1'b1};
    assign quorum_ok = r_hit && (total >= quorum);

    // latch of one beat
    always_comb begin
        case (i_action)
            hbwd_pkg::ACT_SEND: begin
                n_round = r_cur;
                n_mask  = own_bit;
            end
            hbwd_pkg::ACT_RECV: begin
                n_round = i_entry_round;
                n_mask  = i_entry_mask;
            end
            default: begin
                n_round = check_round;
                n_mask  = i_entry_mask;
            end
        endcase
    end

    // result emission
    assign live = i_cmd.scan_chk && r_dv && r_valid[r_dk] && (rd_seen != '0);

    always_comb begin
        n_o_valid    = 1'b0;
        n_o_is_entry = r_o_is_entry;
        n_o_round    = r_o_round;
        n_o_mask     = r_o_mask;
        n_o_last     = r_o_last;
        n_o_timed    = r_o_timed;
        n_pend_v     = r_pend_v;
        if ((live || i_cmd.fin) && r_pend_v) begin
            n_o_valid    = 1'b1;
            n_o_is_entry = 1'b1;
            n_o_round    = r_pend_round;
            n_o_mask     = r_pend_mask;
            n_o_last     = i_cmd.fin;
            n_o_timed    = 1'b0;
        end
        if (i_cmd.to_done) begin
            n_o_valid    = 1'b1;
            n_o_is_entry = 1'b0;
            n_o_round    = '0;
            n_o_mask     = '0;
            n_o_last     = 1'b0;
            n_o_timed    = !r_skip && !quorum_ok;
        end
        if (live) begin
            n_pend_v = 1'b1;
        end
        if (i_cmd.claim_wr || i_cmd.fin) begin
            n_pend_v = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= '0;
            r_faulty  <= '0;
            r_span    <= hbwd_pkg::SPAN_RESET;
            r_cur     <= '0;
            r_valid   <= '0;
            r_dv      <= 1'b0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    hbwd_pkg::CFG_OWN_ID: begin
                        r_own_id <= i_cfg_wdata[hbwd_pkg::OWN_W-1:0];
                    end
                    hbwd_pkg::CFG_FAULTY_COUNT: begin
                        r_faulty <= i_cfg_wdata[hbwd_pkg::FAULTY_W-1:0];
                    end
                    hbwd_pkg::CFG_TIMEOUT_SPAN: begin
                        r_span <= i_cfg_wdata[hbwd_pkg::SPAN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // saturates one below the empty stamp
            if (i_cmd.tick && (r_cur != {{(ROUND_BITS-1){1'b1}}, 1'b0})) begin
                r_cur <= r_cur + ROUND_BITS'(1);
            end
            if (i_cmd.claim_wr) begin
                r_valid[slot] <= 1'b1;
            end else if (i_cmd.to_done && !r_skip) begin
                r_valid[slot] <= 1'b0;
            end
            r_dv      <= i_cmd.scan_rd;
            r_pend_v  <= n_pend_v;
            r_o_valid <= n_o_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_round <= n_round;
            r_mask  <= n_mask;
            r_skip  <= faulty || before_span;
        end
        if (i_cmd.claim_wr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan <= r_scan + LW'(1);
        end
        r_dk <= r_scan;
        if (live) begin
            r_pend_round <= rd_stamp;
            r_pend_mask  <= rd_seen;
        end
        if (i_cmd.to_cnt) begin
            for (int g = 0; g < GROUPS; g++) begin
                r_grp[g] <= grp_cnt[g];
            end
            r_hit <= claim_hit;
        end
        r_o_is_entry <= n_o_is_entry;
        r_o_round    <= n_o_round;
        r_o_mask     <= n_o_mask;
        r_o_last     <= n_o_last;
        r_o_timed    <= n_o_timed;
    end

    assign o_valid     = r_o_valid;
    assign o_is_entry  = r_o_is_entry;
    assign o_out_round = r_o_round;
    assign o_out_mask  = r_o_mask;
    assign o_last      = r_o_last;
    assign o_expired   = r_o_timed;

endmodule

// ----- design/heartbeat_window_failure_detector_core.sv -----
// Top level of the heartbeat window failure detector: controller plus datapath.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------------------
//   command  | i_start, o_busy        | i_action, i_entry_round, i_entry_mask,
//            |                        | i_entry_last
//   result   | o_valid (1-cycle)      | o_is_entry, o_out_round, o_out_mask, o_last,
//            |                        | o_expired
//   config   | i_cfg_we               | i_cfg_addr, i_cfg_wdata
//
// Round tick and dropped send/receive keep busy low. Receive taken: claim read, write.
// Timeout check: read, count, sum; verdict in the first cycle with busy low again.
// Send: claim, scan of the slot RAM through its one read port, drain, finish.
// Synchronous active-low reset empties every slot at once through the valid bits.
// Each result beat is shown for one cycle; the receiver cannot stall.
module heartbeat_window_failure_detector_core #(
    parameter int WINDOW     = hbwd_pkg::WINDOW_DEF,
    parameter int NODES      = hbwd_pkg::NODES_DEF,
    parameter int ROUND_BITS = hbwd_pkg::ROUND_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [hbwd_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [hbwd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             i_start,
    output logic                             o_busy,
    input  logic [hbwd_pkg::ACTION_W-1:0]    i_action,
    input  logic [ROUND_BITS-1:0]            i_entry_round,
    input  logic [NODES-1:0]                 i_entry_mask,
    input  logic                             i_entry_last,
    output logic                             o_valid,
    output logic                             o_is_entry,
    output logic [ROUND_BITS-1:0]            o_out_round,
    output logic [NODES-1:0]                 o_out_mask,
    output logic                             o_last,
    output logic                             o_expired
);

    hbwd_pkg::t_cmd cmd;
    hbwd_pkg::t_sts sts;

    hbwd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    hbwd_dpath #(
        .WINDOW     (WINDOW),
        .NODES      (NODES),
        .ROUND_BITS (ROUND_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_action      (i_action),
        .i_entry_round (i_entry_round),
        .i_entry_mask  (i_entry_mask),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_valid       (o_valid),
        .o_is_entry    (o_is_entry),
        .o_out_round   (o_out_round),
        .o_out_mask    (o_out_mask),
        .o_last        (o_last),
        .o_expired     (o_expired)
    );

`ifndef NO_ASSERTIONS
    a_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action == hbwd_pkg::ACT_TICK)) |=> !o_valid)
        else $error("result beat after a round tick");

    a_check_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_action == hbwd_pkg::ACT_CHECK))
        |-> ##4 (o_valid && !o_is_entry))
        else $error("timeout check gave no verdict beat");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat after the last entry of a send");

    a_verdict_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_entry) |-> !o_busy)
        else $error("verdict beat while busy");
`endif

endmodule
